/* src/sms_pkg.sv */
// shared types and constants for the spi master byte shifter
package sms_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutW     = 16;

  localparam logic [CfgIdxW-1:0] CfgSpiMode       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgClockConn     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMosiConn      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMisoConn      = 3'd4;

  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef enum logic {
    OpTick  = 1'b0,
    OpStart = 1'b1
  } opcode_e;

  // one classified input transaction
  typedef struct packed {
    logic       start;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       miso_level;
  } cmd_t;

  // queue side of the front to back link
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  // one result transaction
  typedef struct packed {
    logic       status;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       chip_select_n;
    logic       mosi_level;
    logic       sck_level;
  } res_t;

endpackage

/* src/sms_front.sv */
// input side: accepts transactions, classifies them and queues them for the engine
module sms_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [15:0]   s_tdata_i,   // tx_byte [7:0], miso_level [8], zero [15:9]
  input  logic          s_tuser_i,   // opcode
  input  logic          s_tlast_i,   // last_byte
  output sms_pkg::cmd_q_t cmd_o,
  input  logic          cmd_pop_i
);
  import sms_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.start      = (opcode_e'(s_tuser_i) == OpStart);
    in_cmd.tx_byte    = s_tdata_i[7:0];
    in_cmd.last_byte  = s_tlast_i;
    in_cmd.miso_level = s_tdata_i[8];
  end

  assign s_tready_o = (count_q != 2'd2);
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = cmd_pop_i && (count_q != 2'd0);

  assign cmd_o.valid = (count_q != 2'd0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 2'd1))
    else $error("queue pop lost");

endmodule

/* src/sms_engine.sv */
// back side: serial engine state, configuration registers and result register
module sms_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [sms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sms_pkg::CfgDataW-1:0] cfg_data_i,
  input  sms_pkg::cmd_q_t cmd_i,
  output logic          cmd_pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [15:0]   m_tdata_o
);
  import sms_pkg::*;

  logic [1:0]  mode_q;
  logic [15:0] hpt_q;
  logic        clk_conn_q, mosi_conn_q, miso_conn_q;

  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic [3:0]  bits_q, bits_d;
  logic        half_q, half_d;
  logic [15:0] timer_q, timer_d;
  logic        active_q, active_d;
  logic        rel_q, rel_d;
  logic        sck_q, sck_d;
  logic        mosi_q, mosi_d;
  logic        sel_q, sel_d;

  logic        out_valid_q;
  res_t        out_q, res;
  logic        cpol, cpha, smp;

  assign cpol      = mode_q[1];
  assign cpha      = mode_q[0];
  assign smp       = miso_conn_q && cmd_i.cmd.miso_level;
  assign cmd_pop_o = cmd_i.valid && (!out_valid_q || m_tready_i);

  always_comb begin
    tx_d     = tx_q;
    rx_d     = rx_q;
    bits_d   = bits_q;
    half_d   = half_q;
    timer_d  = timer_q;
    active_d = active_q;
    rel_d    = rel_q;
    sck_d    = sck_q;
    mosi_d   = mosi_q;
    sel_d    = sel_q;
    res.rx_valid = 1'b0;
    res.rx_byte  = 8'd0;
    res.status   = 1'b0;
    if (cmd_pop_o) begin
      if (active_q) begin
        if (timer_q != 16'd0) begin
          timer_d = timer_q - 16'd1;
        end else if (!half_q) begin
          sck_d = ~cpol;
          if (cpha) begin
            if (mosi_conn_q) mosi_d = tx_q[7];
          end else begin
            rx_d = {rx_q[6:0], smp};
          end
          half_d  = 1'b1;
          timer_d = hpt_q;
        end else begin
          sck_d = cpol;
          if (cpha) rx_d = {rx_q[6:0], smp};
          tx_d    = {tx_q[6:0], 1'b0};
          bits_d  = bits_q - 4'd1;
          half_d  = 1'b0;
          timer_d = hpt_q;
          if (bits_d == 4'd0) begin
            active_d     = 1'b0;
            res.rx_valid = 1'b1;
            res.rx_byte  = rx_d;
            if (rel_q) sel_d = 1'b1;
          end else if (!cpha) begin
            if (mosi_conn_q) mosi_d = tx_d[7];
          end
        end
      end else if (cmd_i.cmd.start) begin
        if (!clk_conn_q) begin
          res.status = 1'b1;
        end else begin
          tx_d     = cmd_i.cmd.tx_byte;
          rx_d     = 8'd0;
          bits_d   = BitsPerByte;
          half_d   = 1'b0;
          timer_d  = hpt_q;
          active_d = 1'b1;
          rel_d    = cmd_i.cmd.last_byte;
          sel_d    = 1'b0;
          sck_d    = cpol;
          if (!cpha && mosi_conn_q) mosi_d = cmd_i.cmd.tx_byte[7];
        end
      end
    end
    if (cfg_we_i && cfg_idx_i == CfgSpiMode && !active_q) begin
      sck_d = cfg_data_i[1];
    end
    res.sck_level     = sck_d;
    res.mosi_level    = mosi_d;
    res.chip_select_n = sel_d;
    res.busy_res      = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 2'd0;
      hpt_q       <= 16'd0;
      clk_conn_q  <= 1'b1;
      mosi_conn_q <= 1'b1;
      miso_conn_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSpiMode:    mode_q      <= cfg_data_i[1:0];
        CfgHalfPeriod: hpt_q       <= cfg_data_i;
        CfgClockConn:  clk_conn_q  <= cfg_data_i[0];
        CfgMosiConn:   mosi_conn_q <= cfg_data_i[0];
        CfgMisoConn:   miso_conn_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q     <= 8'd0;
      rx_q     <= 8'd0;
      bits_q   <= 4'd0;
      half_q   <= 1'b0;
      timer_q  <= 16'd0;
      active_q <= 1'b0;
      rel_q    <= 1'b0;
      sck_q    <= 1'b0;
      mosi_q   <= 1'b1;
      sel_q    <= 1'b1;
    end else begin
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      bits_q   <= bits_d;
      half_q   <= half_d;
      timer_q  <= timer_d;
      active_q <= active_d;
      rel_q    <= rel_d;
      sck_q    <= sck_d;
      mosi_q   <= mosi_d;
      sel_q    <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OutW - $bits(res_t)){1'b0}}, out_q};

  a_active_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !sel_q) else $error("chip select released during transfer");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BitsPerByte) else $error("bit count out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx_valid) |-> !out_q.busy_res)
    else $error("byte reported while still busy");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |=> !$past(cmd_pop_o))
    else $error("engine advanced while result stalled");

endmodule

/* src/spi_master_byte_shifter.sv */
// top level of the spi master byte shifter
// Each input transaction is one tick of the serial engine and yields exactly one result
// transaction. The block takes one transaction per clock cycle unless the result output is
// stalled; a result is offered after passing through the two-entry input queue and the result
// register. A byte takes 16 * (half_period_ticks + 1) ticks after its start tick. Configuration
// writes are taken in any cycle and must be made while no transaction is outstanding.
module spi_master_byte_shifter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // tx_byte [7:0], miso_level [8], zero [15:9]
  input  logic        s_tuser_i,   // opcode
  input  logic        s_tlast_i,   // last_byte
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o    // sck_level, mosi_level, chip_select_n, busy_res,
                                   // rx_valid, rx_byte [12:5], status [13], zero [15:14]
);
  import sms_pkg::*;

  cmd_q_t cmd;
  logic   cmd_pop;

  sms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  sms_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

/* verif/tb_spi_master_byte_shifter.sv */
// testbench for the spi master byte shifter: directed table, then random ticks checked by a predictor
module tb_spi_master_byte_shifter;
  import sms_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 250;
  localparam int SettleCycles = 8;
  localparam res_t Unchecked = '0;

  typedef struct {
    bit                 cfg;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        val;
    opcode_e            op;
    logic [7:0]         tx;
    logic               last;
    logic               miso;
    bit                 typed;
    res_t               want;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [15:0] s_tdata_i = '0;
  logic        s_tuser_i = OpTick;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [15:0] m_tdata_o;

  // predictor state
  logic [1:0]  mode_q = 2'd0;
  logic [15:0] half_q = '0;
  logic        clk_conn = 1'b1;
  logic        mosi_conn = 1'b1;
  logic        miso_conn = 1'b1;
  logic [7:0]  tx_sr = '0;
  logic [7:0]  rx_sr = '0;
  logic [3:0]  bits_rem = '0;
  logic        second_half = 1'b0;
  logic [15:0] phase_cnt = '0;
  logic        xfer_on = 1'b0;
  logic        drop_cs = 1'b0;
  logic        sck_q = 1'b0;
  logic        mosi_q = 1'b1;
  logic        cs_n_q = 1'b1;

  res_t line_levels_q [$];
  res_t mon_want;
  res_t mon_got;
  int   n_bad = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  bit   hold_go = 1'b0;

  step_t steps [27] = '{
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b0, 1'b1,
      res_t'{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{1'b1, CfgClockConn, 16'd0, OpTick, 8'h00, 1'b0, 1'b0, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'h5A, 1'b1, 1'b0, 1'b1,
      res_t'{1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{1'b1, CfgClockConn, 16'd1, OpTick, 8'h00, 1'b0, 1'b0, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'hFF, 1'b1, 1'b1, 1'b1,
      res_t'{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    // start on the completion tick is ignored
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'hFF, 1'b1, 1'b1, 1'b1,
      res_t'{1'b0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{1'b1, CfgSpiMode, 16'd3, OpTick, 8'h00, 1'b0, 1'b0, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b0, 1'b1,
      res_t'{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{1'b0, CfgSpiMode, 16'd0, OpStart, 8'h00, 1'b0, 1'b0, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b0, 1'b0, Unchecked},
    '{1'b0, CfgSpiMode, 16'd0, OpTick, 8'h00, 1'b0, 1'b1, 1'b0, Unchecked}
  };

  spi_master_byte_shifter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .s_tlast_i (s_tlast_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void put_msb();
    if (mosi_conn) mosi_q = tx_sr[7];
  endfunction

  function automatic void take_miso(input logic miso);
    rx_sr = {rx_sr[6:0], miso_conn & miso};
  endfunction

  function automatic void next_line_levels(input opcode_e op, input logic [7:0] tx,
                                           input logic last, input logic miso,
                                           output res_t r);
    logic pol;
    logic pha;
    pol = mode_q[1];
    pha = mode_q[0];
    r = '0;
    if (xfer_on) begin
      if (phase_cnt != 16'd0) begin
        phase_cnt = phase_cnt - 16'd1;
      end else if (!second_half) begin
        sck_q = ~pol;
        if (pha) put_msb();
        else take_miso(miso);
        second_half = 1'b1;
        phase_cnt = half_q;
      end else begin
        sck_q = pol;
        if (pha) take_miso(miso);
        tx_sr = {tx_sr[6:0], 1'b0};
        bits_rem = bits_rem - 4'd1;
        second_half = 1'b0;
        phase_cnt = half_q;
        if (bits_rem == 4'd0) begin
          xfer_on = 1'b0;
          r.rx_valid = 1'b1;
          r.rx_byte = rx_sr;
          if (drop_cs) cs_n_q = 1'b1;
        end else if (!pha) begin
          put_msb();
        end
      end
    end else if (op == OpStart) begin
      if (!clk_conn) begin
        r.status = 1'b1;
      end else begin
        tx_sr = tx;
        rx_sr = '0;
        bits_rem = BitsPerByte;
        second_half = 1'b0;
        phase_cnt = half_q;
        xfer_on = 1'b1;
        drop_cs = last;
        cs_n_q = 1'b0;
        sck_q = pol;
        if (!pha) put_msb();
      end
    end
    r.sck_level = sck_q;
    r.mosi_level = mosi_q;
    r.chip_select_n = cs_n_q;
    r.busy_res = xfer_on;
  endfunction

  task automatic push_item(input opcode_e op, input logic [7:0] tx, input logic last,
                           input logic miso, input bit typed, input res_t want);
    res_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tuser_i <= op;
    s_tlast_i <= last;
    s_tdata_i <= {7'b0, miso, tx};
    do @(posedge clk_i); while (!s_tready_o);
    next_line_levels(op, tx, last, miso, pred);
    line_levels_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (line_levels_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgSpiMode: begin
        mode_q = val[1:0];
        if (!xfer_on) sck_q = val[1];
      end
      CfgHalfPeriod: half_q = val;
      CfgClockConn: clk_conn = val[0];
      CfgMosiConn: mosi_conn = val[0];
      CfgMisoConn: miso_conn = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      mon_got = res_t'(m_tdata_o[13:0]);
      if (line_levels_q.size() == 0) begin
        if (n_bad < 10) $display("unexpected result transaction %h", m_tdata_o);
        n_bad++;
      end else begin
        mon_want = line_levels_q.pop_front();
        if (m_tdata_o !== {2'b00, mon_want}) begin
          if (n_bad < 10) begin
            $display("mismatch exp sck %b mosi %b csn %b busy %b rxv %b rx %h st %b",
                     mon_want.sck_level, mon_want.mosi_level, mon_want.chip_select_n,
                     mon_want.busy_res, mon_want.rx_valid, mon_want.rx_byte,
                     mon_want.status);
            $display("         got sck %b mosi %b csn %b busy %b rxv %b rx %h st %b (raw %h)",
                     mon_got.sck_level, mon_got.mosi_level, mon_got.chip_select_n,
                     mon_got.busy_res, mon_got.rx_valid, mon_got.rx_byte, mon_got.status,
                     m_tdata_o);
          end
          n_bad++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[spi_master_byte_shifter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          ph;
    int          n_items;
    logic [15:0] half;
    opcode_e     op;
    logic [7:0]  tx;
    logic        last_b;
    logic        miso_b;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].cfg) begin
        drain();
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        push_item(steps[i].op, steps[i].tx, steps[i].last, steps[i].miso,
                  steps[i].typed, steps[i].want);
      end
    end

    for (ph = 0; ph < 12; ph++) begin
      drain();
      // slow phase: let the running byte finish before the period goes to its maximum
      if (ph == 5) begin
        while (xfer_on) begin
          miso_b = 1'($urandom_range(0, 1));
          push_item(OpTick, 8'hFF, 1'b0, miso_b, 1'b0, Unchecked);
        end
        drain();
      end
      case (ph % 4)
        0: half = 16'd0;
        1: half = 16'($urandom_range(1, 3));
        2: half = 16'($urandom_range(0, 1));
        default: half = 16'($urandom_range(4, 9));
      endcase
      if (ph == 5) half = 16'hFFFF;
      write_reg(CfgSpiMode, 16'(ph % 4));
      write_reg(CfgHalfPeriod, half);
      write_reg(CfgClockConn, (ph == 5) ? 16'd0 : 16'($urandom_range(0, 7) != 0));
      write_reg(CfgMosiConn, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 3) != 0));
      write_reg(CfgMisoConn, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 3) != 0));

      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      if (ph == 8) hold_go = 1'b1;

      n_items = (ph == 5) ? 40 : $urandom_range(140, 180);
      repeat (n_items) begin
        op = ($urandom_range(0, 99) < 30) ? OpStart : OpTick;
        case ($urandom_range(0, 7))
          0: tx = 8'h00;
          1: tx = 8'hFF;
          default: tx = 8'($urandom);
        endcase
        last_b = 1'($urandom_range(0, 1));
        miso_b = 1'($urandom_range(0, 1));
        push_item(op, tx, last_b, miso_b, 1'b0, Unchecked);
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("[spi_master_byte_shifter] OK");
    end else begin
      $display("[spi_master_byte_shifter] ERROR");
    end
    $finish;
  end

endmodule
